// ----- src/ltd_pkg.sv -----
package ltd_pkg;

  // Default history window in bytes
  localparam int unsigned WINDOW_SIZE_DEF = 32768;

  // Shortest match a token can encode; the length byte holds length minus this
  localparam int unsigned MATCH_MIN = 3;

  // Bytes per output word
  localparam int unsigned WORD_BYTES = 8;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FLAG   = 3'd1;
  localparam logic [2:0] ST_FLAG_BUSY = 3'd2;
  localparam logic [2:0] ST_BAD_DIST  = 3'd3;
  localparam logic [2:0] ST_DONE      = 3'd4;

  // Input item kinds
  localparam logic CMD_FLAG = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  // Token parse phases
  localparam logic [1:0] PH_LEN    = 2'd0;
  localparam logic [1:0] PH_DIST_LO = 2'd1;
  localparam logic [1:0] PH_DIST_HI = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_COPY  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

endpackage

// ----- src/lzss_token_decoder.sv -----
// LZSS token decoder. Items arrive tagged: command 0 carries a flag byte whose
// eight bits are used MSB first, command 1 a data byte. A clear flag bit makes
// the next data byte a literal; a set bit makes the next three data bytes a
// token (length-3, distance low, distance high), copied byte by byte out of a
// WINDOW_SIZE-byte history RAM so overlapping matches repeat correctly.
// Decoded bytes leave in words of up to eight (first byte in bits 7:0), the
// final word of an item flagged with out_last. Decoding stops once
// output_length bytes exist; later items get status "already done". Errors
// give one empty word with out_last set and the status code.
// Timing: flag bytes and the first two token bytes are taken in S_IDLE
// without leaving it. A literal passes through S_COPY and an error through
// S_EMIT, each held by any output stall. After the last byte of a match come
// a distance check in S_CHECK and the copy in S_COPY, which packs the bytes
// into words, held by any output stall and paced by the single read port of
// the history RAM (registered read; write-to-read forwarding covers distance
// one). The input is held off (in_stall high) while a literal, error or match
// is still in progress; a finished word waiting in the output register does
// not block the next item.
// history needs no clearing: only bytes already written can be addressed.
module lzss_token_decoder #(
  parameter int unsigned WINDOW_SIZE = ltd_pkg::WINDOW_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: output_length
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_value,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last,
  output logic [2:0]  out_status
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_SIZE - 1);
  localparam logic [16:0] WIN17 = 17'(WINDOW_SIZE);
  localparam logic [3:0] WORD_N = 4'(ltd_pkg::WORD_BYTES);

  // history RAM
  logic [7:0] hist_mem [WINDOW_SIZE];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_data_r;
  logic [7:0]    rd_byte;

  // control and parse state
  ltd_pkg::state_t state_r, state_nxt;
  logic [31:0]   out_len_r, out_len_nxt;
  logic [31:0]   produced_r, produced_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [7:0]    flag_bits_r, flag_bits_nxt;
  logic [3:0]    flag_left_r, flag_left_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [8:0]    pend_len_r, pend_len_nxt;
  logic [7:0]    pend_dlo_r, pend_dlo_nxt;
  logic [15:0]   dist_r, dist_nxt;
  logic [2:0]    err_r, err_nxt;

  // copy engine
  logic [AW-1:0] rd_r, rd_nxt;
  logic [8:0]    remain_r, remain_nxt;
  logic          rd_pend_r, rd_pend_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic [3:0]    acc_cnt_r, acc_cnt_nxt;

  // output register
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_bytes_r, out_bytes_nxt;
  logic [3:0]    out_cnt_r, out_cnt_nxt;
  logic          out_last_r, out_last_nxt;
  logic [2:0]    out_status_r, out_status_nxt;

  logic        in_xfer;
  logic        out_free;
  logic        is_done;
  logic        bad_dist;
  logic [31:0] avail;
  logic [16:0] rd_diff;
  logic [AW-1:0] rd_start;
  logic        last_word;
  logic        drain;
  logic        flush;
  logic        issue;
  logic [63:0] acc_base;
  logic [3:0]  acc_base_cnt;

  assign in_stall = (state_r != ltd_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign is_done  = (produced_r >= out_len_r);

  // distance check and match setup, in the cycle after the last token byte
  assign bad_dist = (dist_r == 16'd0) || ({1'b0, dist_r} > WIN17) ||
                    ({16'd0, dist_r} > produced_r);
  assign avail    = out_len_r - produced_r;
  assign rd_diff  = 17'(wp_r) - {1'b0, dist_r};
  assign rd_start = (17'(wp_r) >= {1'b0, dist_r}) ? rd_diff[AW-1:0]
                                                  : AW'(rd_diff + WIN17);

  // copy pacing: at most eight bytes held or in flight
  assign last_word = (remain_r == 9'd0) && !rd_pend_r;
  assign drain     = last_word && (acc_cnt_r != 4'd0);
  assign flush     = (state_r == ltd_pkg::S_COPY) && out_free &&
                     ((acc_cnt_r == WORD_N) || drain);
  assign issue     = (state_r == ltd_pkg::S_COPY) && (remain_r != 9'd0) &&
                     (((acc_cnt_r + {3'd0, rd_pend_r}) < WORD_N) || flush);
  assign acc_base     = flush ? 64'd0 : acc_r;
  assign acc_base_cnt = flush ? 4'd0 : acc_cnt_r;

  // read data, with forwarding when the same entry was written as it was read
  assign rd_byte = fwd_hit_r ? fwd_data_r : mem_rdata_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wp_r;
    mem_wdata = rd_byte;
    if (state_r == ltd_pkg::S_COPY && rd_pend_r) begin
      mem_we = 1'b1;
    end else if (state_r == ltd_pkg::S_IDLE && in_xfer && !is_done &&
                 in_command == ltd_pkg::CMD_DATA && flag_left_r != 4'd0 &&
                 !flag_bits_r[7]) begin
      mem_we    = 1'b1;
      mem_wdata = in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= hist_mem[rd_r];
    fwd_hit_r   <= mem_we && (mem_waddr == rd_r);
    fwd_data_r  <= mem_wdata;
  end

  always_comb begin
    state_nxt      = state_r;
    out_len_nxt    = cfg_we ? cfg_wdata : out_len_r;
    produced_nxt   = produced_r;
    wp_nxt         = wp_r;
    flag_bits_nxt  = flag_bits_r;
    flag_left_nxt  = flag_left_r;
    phase_nxt      = phase_r;
    pend_len_nxt   = pend_len_r;
    pend_dlo_nxt   = pend_dlo_r;
    dist_nxt       = dist_r;
    err_nxt        = err_r;
    rd_nxt         = rd_r;
    remain_nxt     = remain_r;
    rd_pend_nxt    = 1'b0;
    acc_nxt        = acc_r;
    acc_cnt_nxt    = acc_cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_bytes_nxt  = out_bytes_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    // every history write appends one output byte
    if (mem_we) begin
      wp_nxt       = (wp_r == LAST_ADDR) ? '0 : wp_r + 1'b1;
      produced_nxt = produced_r + 32'd1;
    end

    unique case (state_r)
      ltd_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (is_done) begin
            err_nxt   = ltd_pkg::ST_DONE;
            state_nxt = ltd_pkg::S_EMIT;
          end else if (in_command == ltd_pkg::CMD_FLAG) begin
            if (flag_left_r != 4'd0) begin
              err_nxt   = ltd_pkg::ST_FLAG_BUSY;
              state_nxt = ltd_pkg::S_EMIT;
            end else begin
              flag_bits_nxt = in_value;
              flag_left_nxt = WORD_N;
            end
          end else if (flag_left_r == 4'd0) begin
            err_nxt   = ltd_pkg::ST_NO_FLAG;
            state_nxt = ltd_pkg::S_EMIT;
          end else if (!flag_bits_r[7]) begin
            // literal: written above, sent as a one-byte word
            flag_bits_nxt = {flag_bits_r[6:0], 1'b0};
            flag_left_nxt = flag_left_r - 4'd1;
            acc_nxt       = {56'd0, in_value};
            acc_cnt_nxt   = 4'd1;
            remain_nxt    = 9'd0;
            state_nxt     = ltd_pkg::S_COPY;
          end else begin
            unique case (phase_r)
              ltd_pkg::PH_LEN: begin
                pend_len_nxt = {1'b0, in_value} + 9'(ltd_pkg::MATCH_MIN);
                phase_nxt    = ltd_pkg::PH_DIST_LO;
              end
              ltd_pkg::PH_DIST_LO: begin
                pend_dlo_nxt = in_value;
                phase_nxt    = ltd_pkg::PH_DIST_HI;
              end
              default: begin
                dist_nxt      = {in_value, pend_dlo_r};
                phase_nxt     = ltd_pkg::PH_LEN;
                flag_bits_nxt = {flag_bits_r[6:0], 1'b0};
                flag_left_nxt = flag_left_r - 4'd1;
                state_nxt     = ltd_pkg::S_CHECK;
              end
            endcase
          end
        end
      end

      ltd_pkg::S_CHECK: begin
        if (bad_dist) begin
          err_nxt   = ltd_pkg::ST_BAD_DIST;
          state_nxt = ltd_pkg::S_EMIT;
        end else begin
          // clip the copy at the configured output length
          remain_nxt  = (avail < {23'd0, pend_len_r}) ? avail[8:0] : pend_len_r;
          rd_nxt      = rd_start;
          acc_nxt     = 64'd0;
          acc_cnt_nxt = 4'd0;
          state_nxt   = ltd_pkg::S_COPY;
        end
      end

      ltd_pkg::S_COPY: begin
        acc_nxt     = acc_base;
        acc_cnt_nxt = acc_base_cnt;
        if (rd_pend_r) begin
          acc_nxt[acc_base_cnt[2:0]*8 +: 8] = rd_byte;
          acc_cnt_nxt = acc_base_cnt + 4'd1;
        end
        if (issue) begin
          rd_pend_nxt = 1'b1;
          rd_nxt      = (rd_r == LAST_ADDR) ? '0 : rd_r + 1'b1;
          remain_nxt  = remain_r - 9'd1;
        end
        if (flush) begin
          out_valid_nxt  = 1'b1;
          out_bytes_nxt  = acc_r;
          out_cnt_nxt    = acc_cnt_r;
          out_last_nxt   = last_word;
          out_status_nxt = ltd_pkg::ST_OK;
          if (last_word) begin
            state_nxt = ltd_pkg::S_IDLE;
          end
        end
      end

      ltd_pkg::S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_bytes_nxt  = 64'd0;
          out_cnt_nxt    = 4'd0;
          out_last_nxt   = 1'b1;
          out_status_nxt = err_r;
          state_nxt      = ltd_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = ltd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ltd_pkg::S_IDLE;
      out_len_r   <= 32'd0;
      produced_r  <= 32'd0;
      wp_r        <= '0;
      flag_bits_r <= 8'd0;
      flag_left_r <= 4'd0;
      phase_r     <= ltd_pkg::PH_LEN;
      pend_len_r  <= 9'd0;
      pend_dlo_r  <= 8'd0;
      rd_pend_r   <= 1'b0;
      remain_r    <= 9'd0;
      acc_cnt_r   <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_len_r   <= out_len_nxt;
      produced_r  <= produced_nxt;
      wp_r        <= wp_nxt;
      flag_bits_r <= flag_bits_nxt;
      flag_left_r <= flag_left_nxt;
      phase_r     <= phase_nxt;
      pend_len_r  <= pend_len_nxt;
      pend_dlo_r  <= pend_dlo_nxt;
      rd_pend_r   <= rd_pend_nxt;
      remain_r    <= remain_nxt;
      acc_cnt_r   <= acc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    dist_r       <= dist_nxt;
    err_r        <= err_nxt;
    rd_r         <= rd_nxt;
    acc_r        <= acc_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_bytes      = out_bytes_r;
  assign out_byte_count = out_cnt_r;
  assign out_last       = out_last_r;
  assign out_status     = out_status_r;

endmodule
